// ===== rtl/sep2d_pkg.sv =====
package sep2d_pkg;

  localparam int MaxTaps      = 5;
  localparam int MaxWidth     = 1024;
  localparam int MaxHeight    = 4096;
  localparam int PixelBits    = 16;
  localparam int CoefBits     = 16;
  localparam int CoefFracBits = 14;
  localparam int Lines        = 4;
  localparam int RowBits      = PixelBits + 8;
  localparam int OutBits      = 32;
  localparam int ColBits      = 10;
  localparam int RowCntBits   = 13;
  localparam int BankBits     = 2;
  localparam int RowProdBits  = PixelBits + 1 + CoefBits;
  localparam int RowAccBits   = RowProdBits + 3;
  localparam int ColProdBits  = RowBits + CoefBits;
  localparam int ColAccBits   = ColProdBits + 3;
  localparam int RndBits      = 48;

  typedef enum logic [2:0] {
    CfgWidth  = 3'd0,
    CfgHeight = 3'd1,
    CfgTaps   = 3'd2,
    CfgCoef0  = 3'd3,
    CfgCoef1  = 3'd4,
    CfgCoef2  = 3'd5,
    CfgCoef3  = 3'd6,
    CfgCoef4  = 3'd7
  } cfg_idx_e;

  typedef logic signed [RowBits-1:0] row_val_t;

  typedef struct packed {
    logic                en;
    logic [BankBits-1:0] bank;
    logic [ColBits-1:0]  addr;
    row_val_t            data;
  } ls_wr_t;

  // Round half up (floor of v + 0.5), then clamp to the row value range.
  function automatic row_val_t row_round(input logic signed [RowAccBits-1:0] acc);
    logic signed [RndBits-1:0] v;
    v = RndBits'(acc) + RndBits'(1 << (CoefFracBits - 1));
    v = v >>> CoefFracBits;
    if (v[RndBits-1:RowBits-1] == '0 || v[RndBits-1:RowBits-1] == '1) begin
      return v[RowBits-1:0];
    end else if (v[RndBits-1]) begin
      return {1'b1, {(RowBits-1){1'b0}}};
    end else begin
      return {1'b0, {(RowBits-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [OutBits-1:0] col_round(
      input logic signed [ColAccBits-1:0] acc);
    logic signed [RndBits-1:0] v;
    v = RndBits'(acc) + RndBits'(1 << (CoefFracBits - 1));
    v = v >>> CoefFracBits;
    if (v[RndBits-1:OutBits-1] == '0 || v[RndBits-1:OutBits-1] == '1) begin
      return v[OutBits-1:0];
    end else if (v[RndBits-1]) begin
      return {1'b1, {(OutBits-1){1'b0}}};
    end else begin
      return {1'b0, {(OutBits-1){1'b1}}};
    end
  endfunction

endpackage

// ===== rtl/sep2d_line_store.sv =====
module sep2d_line_store (
  input  logic                                                     clk_i,
  input  sep2d_pkg::ls_wr_t                                        wr_i,
  input  logic                                                     rd_en_i,
  input  logic [sep2d_pkg::ColBits-1:0]                            rd_addr_i,
  output logic [sep2d_pkg::Lines-1:0][sep2d_pkg::RowBits-1:0]      rd_data_o
);

  for (genvar b = 0; b < sep2d_pkg::Lines; b++) begin : g_bank
    logic [sep2d_pkg::RowBits-1:0] mem [sep2d_pkg::MaxWidth];
    logic [sep2d_pkg::RowBits-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (wr_i.en && wr_i.bank == sep2d_pkg::BankBits'(b)) begin
        mem[wr_i.addr] <= wr_i.data;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rd_en_i) begin
        rd_q <= mem[rd_addr_i];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

// ===== rtl/separable_2d_convolution.sv =====
// Throughput: one pixel per cycle; a stalled output freezes the whole pipe.
// After the tap select register, row products, row sum, column products and
// column sum each take one stage, the last one being the output register.
// Reset (rst_ni low, asynchronous) restores default sizes and kernel, clears
// the raster position, pixel window and pipeline; line store is not cleared.
module separable_2d_convolution (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [2:0]                           cfg_index_i,
  input  logic [15:0]                          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [sep2d_pkg::PixelBits-1:0]      pixel_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [sep2d_pkg::OutBits-1:0] filtered_value_o,
  output logic [11:0]                          out_row_o,
  output logic [sep2d_pkg::ColBits-1:0]        out_col_o,
  output logic                                 last_in_frame_o,
  output logic                                 size_error_o
);

  localparam int T = sep2d_pkg::MaxTaps;

  typedef struct packed {
    logic                                   valid;
    logic                                   emit;
    logic                                   write;
    logic                                   err;
    logic                                   last;
    logic [11:0]                            orow;
    logic [sep2d_pkg::ColBits-1:0]          rcol;
    logic [sep2d_pkg::BankBits-1:0]         wbank;
    logic [T-1:0]                           cmask;
    logic [T-1:0]                           crv;
    logic [T-1:0][sep2d_pkg::BankBits-1:0]  csel;
  } ctl_t;

  // configuration
  logic [10:0]                          width_q;
  logic [12:0]                          height_q;
  logic [2:0]                           taps_q;
  logic signed [sep2d_pkg::CoefBits-1:0] coef_q [T];

  logic [10:0] w_c;
  logic [12:0] h_c;
  logic [2:0]  t_c, half, lag;
  logic        err;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= 11'd640;
      height_q  <= 13'd480;
      taps_q    <= 3'd3;
      coef_q[0] <= 16'sd4096;
      coef_q[1] <= 16'sd8192;
      coef_q[2] <= 16'sd4096;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
    end else if (cfg_valid_i) begin
      case (sep2d_pkg::cfg_idx_e'(cfg_index_i))
        sep2d_pkg::CfgWidth:  width_q   <= cfg_data_i[10:0];
        sep2d_pkg::CfgHeight: height_q  <= cfg_data_i[12:0];
        sep2d_pkg::CfgTaps:   taps_q    <= cfg_data_i[2:0];
        sep2d_pkg::CfgCoef0:  coef_q[0] <= cfg_data_i;
        sep2d_pkg::CfgCoef1:  coef_q[1] <= cfg_data_i;
        sep2d_pkg::CfgCoef2:  coef_q[2] <= cfg_data_i;
        sep2d_pkg::CfgCoef3:  coef_q[3] <= cfg_data_i;
        sep2d_pkg::CfgCoef4:  coef_q[4] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (width_q == '0) ? 11'd1 :
          (width_q > 11'(sep2d_pkg::MaxWidth)) ? 11'(sep2d_pkg::MaxWidth) : width_q;
    h_c = (height_q == '0) ? 13'd1 :
          (height_q > 13'(sep2d_pkg::MaxHeight)) ? 13'(sep2d_pkg::MaxHeight) : height_q;
    t_c = (taps_q == '0) ? 3'd1 : (taps_q > 3'(T)) ? 3'(T) : taps_q;
    half = t_c >> 1;
    lag  = t_c - 3'd1 - half;
    err  = (w_c < 11'(t_c)) || (h_c < 13'(t_c));
  end

  // pipeline control
  logic adv, accept;
  logic out_valid_q;

  assign adv        = !out_valid_q || !out_stall_i;
  assign accept     = in_valid_i && adv;
  assign in_stall_o = !adv;

  // front end: position tracking, window and tap selection
  logic [sep2d_pkg::ColBits-1:0]    in_col_q, in_col_d;
  logic [sep2d_pkg::RowCntBits-1:0] in_row_q, in_row_d;
  logic [sep2d_pkg::PixelBits-1:0]  win_q [T];
  logic [sep2d_pkg::PixelBits-1:0]  win_n [T];
  logic [sep2d_pkg::PixelBits-1:0]  rpix_n [T];

  logic                             row_pass, wrap, emit_ok, last;
  logic [sep2d_pkg::ColBits-1:0]    rcol;
  logic [sep2d_pkg::RowCntBits-1:0] rrow, orow;
  ctl_t                             ctl_n;

  always_comb begin
    logic [11:0]                      cc;
    logic [2:0]                       d;
    logic [2:0]                       idx;
    logic [sep2d_pkg::RowCntBits-1:0] r;

    win_n[0] = flush_i ? '0 : pixel_i;
    for (int k = 1; k < T; k++) begin
      win_n[k] = win_q[k-1];
    end

    wrap     = in_col_q < sep2d_pkg::ColBits'(lag);
    row_pass = !(in_row_q == '0 && wrap);
    rcol     = wrap ? sep2d_pkg::ColBits'(11'(in_col_q) + w_c - 11'(lag))
                    : in_col_q - sep2d_pkg::ColBits'(lag);
    rrow     = wrap ? in_row_q - 13'd1 : in_row_q;
    emit_ok  = rrow >= 13'(lag);
    orow     = rrow - 13'(lag);
    last     = row_pass && emit_ok && (orow >= h_c - 13'd1) && (11'(rcol) == w_c - 11'd1);

    ctl_n       = '0;
    ctl_n.valid = in_valid_i;
    ctl_n.err   = err;
    ctl_n.emit  = err || (row_pass && emit_ok);
    ctl_n.write = !err && row_pass;
    ctl_n.last  = !err && last;
    ctl_n.orow  = err ? '0 : orow[11:0];
    ctl_n.rcol  = err ? '0 : rcol;
    ctl_n.wbank = rrow[sep2d_pkg::BankBits-1:0];

    for (int t = 0; t < T; t++) begin
      // row tap: column rcol + t - half must lie inside the row
      cc  = 12'(rcol) + 12'(t) - 12'(half);
      idx = t_c - 3'd1 - 3'(t);
      rpix_n[t] = (!err && 3'(t) < t_c && !cc[11] && cc < 12'(w_c)) ? win_n[idx] : '0;
      // column tap: row rrow - d, with d = 0 taken from the fresh row value
      d = t_c - 3'd1 - 3'(t);
      r = rrow - 13'(d);
      ctl_n.cmask[t] = !err && 3'(t) < t_c && rrow >= 13'(d) && r < h_c;
      ctl_n.crv[t]   = d == '0;
      ctl_n.csel[t]  = r[sep2d_pkg::BankBits-1:0];
    end

    in_col_d = in_col_q;
    in_row_d = in_row_q;
    if (11'(in_col_q) + 11'd1 >= w_c) begin
      in_col_d = '0;
      in_row_d = in_row_q + 13'd1;
    end else begin
      in_col_d = in_col_q + 10'd1;
    end
    if (last) begin
      in_col_d = '0;
      in_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      for (int k = 0; k < T; k++) begin
        win_q[k] <= '0;
      end
    end else if (accept && !err) begin
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      for (int k = 0; k < T; k++) begin
        win_q[k] <= last ? '0 : win_n[k];
      end
    end
  end

  // stages
  ctl_t c1_q, c2_q, c3_q, c4_q;
  logic [sep2d_pkg::PixelBits-1:0]          rpix1_q  [T];
  logic signed [sep2d_pkg::RowProdBits-1:0] rprod2_q [T];
  sep2d_pkg::row_val_t                      rv3_q;
  logic signed [sep2d_pkg::ColProdBits-1:0] cprod4_q [T];

  logic [sep2d_pkg::Lines-1:0][sep2d_pkg::RowBits-1:0] rd3;
  sep2d_pkg::ls_wr_t                                   ls_wr;

  logic signed [sep2d_pkg::RowAccBits-1:0] racc;
  sep2d_pkg::row_val_t                     rv;
  logic signed [sep2d_pkg::ColAccBits-1:0] cacc;
  logic signed [sep2d_pkg::OutBits-1:0]    fv;
  logic signed [sep2d_pkg::ColProdBits-1:0] cprod_n [T];
  logic signed [sep2d_pkg::RowProdBits-1:0] rprod_n [T];

  always_comb begin
    racc = '0;
    cacc = '0;
    for (int t = 0; t < T; t++) begin
      rprod_n[t] = coef_q[t] * $signed({1'b0, rpix1_q[t]});
      racc = racc + sep2d_pkg::RowAccBits'(rprod2_q[t]);
      if (!c3_q.cmask[t]) begin
        cprod_n[t] = '0;
      end else if (c3_q.crv[t]) begin
        cprod_n[t] = coef_q[t] * rv3_q;
      end else begin
        cprod_n[t] = coef_q[t] * $signed(rd3[c3_q.csel[t]]);
      end
      cacc = cacc + sep2d_pkg::ColAccBits'(cprod4_q[t]);
    end
    rv = sep2d_pkg::row_round(racc);
    fv = sep2d_pkg::col_round(cacc);
  end

  assign ls_wr.en   = adv && c2_q.valid && c2_q.write;
  assign ls_wr.bank = c2_q.wbank;
  assign ls_wr.addr = c2_q.rcol;
  assign ls_wr.data = rv;

  sep2d_line_store u_line_store (
    .clk_i     (clk_i),
    .wr_i      (ls_wr),
    .rd_en_i   (adv),
    .rd_addr_i (c2_q.rcol),
    .rd_data_o (rd3)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      c4_q <= '0;
    end else if (adv) begin
      c1_q <= ctl_n;
      c2_q <= c1_q;
      c3_q <= c2_q;
      c4_q <= c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rv3_q <= rv;
      for (int t = 0; t < T; t++) begin
        rpix1_q[t]  <= rpix_n[t];
        rprod2_q[t] <= rprod_n[t];
        cprod4_q[t] <= cprod_n[t];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= c4_q.valid && c4_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      filtered_value_o <= fv;
      out_row_o        <= c4_q.orow;
      out_col_o        <= c4_q.rcol;
      last_in_frame_o  <= c4_q.last;
      size_error_o     <= c4_q.err;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && size_error_o |-> filtered_value_o == '0 && !last_in_frame_o)
    else $error("size error result carries data");

  a_err_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && err |=> in_col_q == $past(in_col_q) && in_row_q == $past(in_row_q))
    else $error("position moved on size error");

  a_last_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !err && last |=> in_col_q == '0 && in_row_q == '0)
    else $error("position not cleared at frame end");

  a_no_err_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_wr.en |-> !c2_q.err)
    else $error("line store written by size error transaction");
`endif

endmodule
